// ===== rtl/spet_pkg.sv =====
// Shared types, constants and helper functions for the pair energy table.
package spet_pkg;

    // Table geometry
    localparam int MAX_PARTICLES = 64;
    localparam int STORE_DEPTH   = (MAX_PARTICLES * (MAX_PARTICLES + 1)) / 2;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int IDX_W         = 6;
    localparam int CNT_W         = 7;
    localparam int ENERGY_W      = 32;
    localparam int VAL_W         = 48;

    localparam logic [CNT_W-1:0]  COUNT_RESET = CNT_W'(64);
    localparam logic [CNT_W-1:0]  COUNT_MAX   = CNT_W'(MAX_PARTICLES);
    localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(STORE_DEPTH - 1);

    // Request kinds
    typedef enum logic [1:0] {
        REQ_SET   = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CHECK = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EQUAL = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Memory address source
    typedef enum logic [2:0] {
        ADR_PAIR,
        ADR_DIAG_A,
        ADR_DIAG_B,
        ADR_ROW,
        ADR_LINEAR
    } t_addr_sel;

    // Memory write data source
    typedef enum logic [1:0] {
        WR_ENERGY,
        WR_DIAG_ADD,
        WR_ZERO,
        WR_SUM
    } t_wr_sel;

    // Controller states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SET_RD,
        S_SET_WR,
        S_DA_RD,
        S_DA_WR,
        S_DB_RD,
        S_DB_WR,
        S_READ_RD,
        S_READ_WAIT,
        S_WALK,
        S_WALK_END,
        S_FIX,
        S_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic      load;       // capture the input transaction
        logic      mem_rd;
        logic      mem_wr;
        t_addr_sel addr_sel;
        t_wr_sel   wr_sel;
        logic      cap_old;    // take old pair value and delta from read data
        logic      add_delta;  // total += 2 * delta
        logic      walk_clr;
        logic      walk_inc;
        logic      acc_issue;  // current read belongs to the row walk
        logic      sum_clr;
        logic      fix;        // correct diagonal sum into total and flag
        logic      total_clr;
        logic      out_load;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        t_req req;
        logic req_err;     // range or equal-index error on the held request
        logic mismatch;    // row sum differs from stored diagonal
        logic row_last;    // row walk at last particle
        logic clear_last;  // sweep at last entry
        logic out_free;    // output register can take a result
    } t_dp_stat;

    // Base entry of row i in packed lower-triangular storage
    function automatic logic [ADDR_W-1:0] tri_base(input logic [IDX_W-1:0] i);
        logic [ADDR_W:0] prod;
        prod = (ADDR_W+1)'(i) * ((ADDR_W+1)'(i) + (ADDR_W+1)'(1));
        return prod[ADDR_W:1];
    endfunction

    // Entry of the pair (x, y) in either order
    function automatic logic [ADDR_W-1:0] slot_of(input logic [IDX_W-1:0] x,
                                                  input logic [IDX_W-1:0] y);
        logic [ADDR_W-1:0] addr;
        if (x > y) begin
            addr = tri_base(x) + ADDR_W'(y);
        end else begin
            addr = tri_base(y) + ADDR_W'(x);
        end
        return addr;
    endfunction

endpackage

// ===== rtl/spet_ctrl.sv =====
// Controller state machine sequencing memory accesses for each request.
module spet_ctrl
    import spet_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_axis_tvalid,
    input  t_dp_stat i_stat,
    output logic     o_s_axis_tready,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_clr_res, n_clr_res;

    // State register; reset starts with a clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_res <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_res <= n_clr_res;
        end
    end

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        n_clr_res       = r_clr_res;
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.mem_wr   = 1'b1;
                o_cmd.addr_sel = ADR_LINEAR;
                o_cmd.wr_sel   = WR_ZERO;
                if (i_stat.clear_last) begin
                    o_cmd.walk_clr  = 1'b1;
                    o_cmd.total_clr = 1'b1;
                    n_state         = r_clr_res ? S_DONE : S_IDLE;
                end else begin
                    o_cmd.walk_inc = 1'b1;
                end
            end
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.sum_clr  = 1'b1;
                o_cmd.walk_clr = 1'b1;
                if (i_stat.req_err) begin
                    n_state = S_DONE;
                end else begin
                    unique case (i_stat.req)
                        REQ_SET:   n_state = S_SET_RD;
                        REQ_READ:  n_state = S_READ_RD;
                        REQ_CHECK: n_state = S_WALK;
                        REQ_CLEAR: begin
                            n_clr_res = 1'b1;
                            n_state   = S_CLEAR;
                        end
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            // Set: fetch old pair value, write new one
            S_SET_RD: begin
                o_cmd.mem_rd   = 1'b1;
                o_cmd.addr_sel = ADR_PAIR;
                n_state        = S_SET_WR;
            end
            S_SET_WR: begin
                o_cmd.cap_old  = 1'b1;
                o_cmd.mem_wr   = 1'b1;
                o_cmd.addr_sel = ADR_PAIR;
                o_cmd.wr_sel   = WR_ENERGY;
                n_state        = S_DA_RD;
            end
            // Move both diagonals and the total by the delta
            S_DA_RD: begin
                o_cmd.mem_rd    = 1'b1;
                o_cmd.addr_sel  = ADR_DIAG_A;
                o_cmd.add_delta = 1'b1;
                n_state         = S_DA_WR;
            end
            S_DA_WR: begin
                o_cmd.mem_wr   = 1'b1;
                o_cmd.addr_sel = ADR_DIAG_A;
                o_cmd.wr_sel   = WR_DIAG_ADD;
                n_state        = S_DB_RD;
            end
            S_DB_RD: begin
                o_cmd.mem_rd   = 1'b1;
                o_cmd.addr_sel = ADR_DIAG_B;
                n_state        = S_DB_WR;
            end
            S_DB_WR: begin
                o_cmd.mem_wr   = 1'b1;
                o_cmd.addr_sel = ADR_DIAG_B;
                o_cmd.wr_sel   = WR_DIAG_ADD;
                n_state        = S_DONE;
            end
            // Read: one fetch
            S_READ_RD: begin
                o_cmd.mem_rd   = 1'b1;
                o_cmd.addr_sel = ADR_PAIR;
                n_state        = S_READ_WAIT;
            end
            S_READ_WAIT: begin
                o_cmd.cap_old = 1'b1;
                n_state       = S_DONE;
            end
            // Recheck: walk the row, one entry per cycle
            S_WALK: begin
                o_cmd.mem_rd    = 1'b1;
                o_cmd.addr_sel  = ADR_ROW;
                o_cmd.acc_issue = 1'b1;
                if (i_stat.row_last) begin
                    o_cmd.walk_clr = 1'b1;
                    n_state        = S_WALK_END;
                end else begin
                    o_cmd.walk_inc = 1'b1;
                end
            end
            S_WALK_END: begin
                n_state = S_FIX;
            end
            S_FIX: begin
                o_cmd.fix      = 1'b1;
                o_cmd.addr_sel = ADR_DIAG_A;
                o_cmd.wr_sel   = WR_SUM;
                o_cmd.mem_wr   = i_stat.mismatch;
                n_state        = S_DONE;
            end
            // Hand the result to the output register
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_clr_res      = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // A result is only produced once the output register is free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("result loaded while output register busy");

    // An accepted transaction is always checked on the next cycle
    a_load_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_CHECK))
        else $error("accepted transaction not checked");

    // A request clear always ends in a result, a reset clear in idle
    a_clear_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) && i_stat.clear_last && r_clr_res |=> (r_state == S_DONE))
        else $error("clear request lost its result");

endmodule

// ===== rtl/spet_dpath.sv =====
// Datapath: pair store memory, accumulators, total and output register.
module spet_dpath
    import spet_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [CNT_W-1:0]    i_cfg_wr_data,
    input  t_req                i_req,
    input  logic [IDX_W-1:0]    i_first_index,
    input  logic [IDX_W-1:0]    i_second_index,
    input  logic [ENERGY_W-1:0] i_pair_energy,
    input  logic                i_m_axis_tready,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    output logic                o_m_axis_tvalid,
    output logic [VAL_W-1:0]    o_value,
    output logic [VAL_W-1:0]    o_total_energy,
    output t_status             o_status,
    output logic                o_sum_mismatch
);

    logic [CNT_W-1:0]    r_count;
    t_req                r_req;
    logic [IDX_W-1:0]    r_a;
    logic [IDX_W-1:0]    r_b;
    logic [VAL_W-1:0]    r_energy;
    logic [ADDR_W-1:0]   r_walk;
    logic [VAL_W-1:0]    r_mem [STORE_DEPTH];
    logic [VAL_W-1:0]    r_rd_data;
    logic [VAL_W-1:0]    r_old;
    logic [VAL_W-1:0]    r_delta;
    logic [VAL_W-1:0]    r_sum;
    logic [VAL_W-1:0]    r_diag;
    logic [VAL_W-1:0]    r_total;
    logic                r_acc_vld;
    logic                r_acc_diag;
    logic                r_mis;
    logic                r_out_valid;
    logic [VAL_W-1:0]    r_out_value;
    logic [VAL_W-1:0]    r_out_total;
    t_status             r_out_status;
    logic                r_out_mis;

    logic [CNT_W-1:0]    live_n;
    logic                range_err;
    logic                equal_err;
    t_status             cur_status;
    logic [ADDR_W-1:0]   mem_addr;
    logic [VAL_W-1:0]    mem_wdata;
    logic [VAL_W-1:0]    res_value;
    logic                out_free;

    // Effective particle count and request checks
    assign live_n    = (r_count > COUNT_MAX) ? COUNT_MAX : r_count;
    always_comb begin
        range_err = 1'b0;
        unique case (r_req)
            REQ_SET, REQ_READ:
                range_err = ({1'b0, r_a} >= live_n) || ({1'b0, r_b} >= live_n);
            REQ_CHECK:
                range_err = ({1'b0, r_a} >= live_n);
            default:
                range_err = 1'b0;
        endcase
    end
    assign equal_err  = (r_req == REQ_SET) && (r_a == r_b);
    assign cur_status = range_err ? ST_RANGE : (equal_err ? ST_EQUAL : ST_OK);
    assign out_free   = !r_out_valid || i_m_axis_tready;

    // Status to controller
    assign o_stat.req        = r_req;
    assign o_stat.req_err    = range_err || equal_err;
    assign o_stat.mismatch   = (r_sum != r_diag);
    assign o_stat.row_last   = (r_walk[CNT_W-1:0] == (live_n - CNT_W'(1)));
    assign o_stat.clear_last = (r_walk == LAST_ADDR);
    assign o_stat.out_free   = out_free;

    // Address and write data selection
    always_comb begin
        unique case (i_cmd.addr_sel)
            ADR_PAIR:   mem_addr = slot_of(r_a, r_b);
            ADR_DIAG_A: mem_addr = slot_of(r_a, r_a);
            ADR_DIAG_B: mem_addr = slot_of(r_b, r_b);
            ADR_ROW:    mem_addr = slot_of(r_a, r_walk[IDX_W-1:0]);
            ADR_LINEAR: mem_addr = r_walk;
            default:    mem_addr = r_walk;
        endcase
        unique case (i_cmd.wr_sel)
            WR_ENERGY:   mem_wdata = r_energy;
            WR_DIAG_ADD: mem_wdata = r_rd_data + r_delta;
            WR_ZERO:     mem_wdata = '0;
            WR_SUM:      mem_wdata = r_sum;
            default:     mem_wdata = '0;
        endcase
    end

    // Single-port pair store with registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[mem_addr] <= mem_wdata;
        end else if (i_cmd.mem_rd) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    // Configuration register and walk position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
            r_walk  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_count <= i_cfg_wr_data;
            end
            if (i_cmd.walk_clr) begin
                r_walk <= '0;
            end else if (i_cmd.walk_inc) begin
                r_walk <= r_walk + ADDR_W'(1);
            end
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= i_req;
            r_a      <= i_first_index;
            r_b      <= i_second_index;
            r_energy <= {{(VAL_W-ENERGY_W){i_pair_energy[ENERGY_W-1]}}, i_pair_energy};
        end
    end

    // Old value, delta, row accumulation and mismatch flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_old <= '0;
            r_mis <= 1'b0;
        end else if (i_cmd.cap_old) begin
            r_old   <= r_rd_data;
            r_delta <= r_energy - r_rd_data;
        end else if (i_cmd.fix) begin
            r_mis <= (r_sum != r_diag);
        end
        if (i_cmd.sum_clr) begin
            r_sum  <= '0;
            r_diag <= '0;
        end else if (r_acc_vld) begin
            if (r_acc_diag) begin
                r_diag <= r_rd_data;
            end else begin
                r_sum <= r_sum + r_rd_data;
            end
        end
    end

    // Track which walk reads return data next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld  <= 1'b0;
            r_acc_diag <= 1'b0;
        end else begin
            r_acc_vld  <= i_cmd.acc_issue;
            r_acc_diag <= (r_walk[IDX_W-1:0] == r_a);
        end
    end

    // Running twice-total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cmd.total_clr) begin
            r_total <= '0;
        end else if (i_cmd.add_delta) begin
            r_total <= r_total + {r_delta[VAL_W-2:0], 1'b0};
        end else if (i_cmd.fix && (r_sum != r_diag)) begin
            r_total <= r_total + r_sum - r_diag;
        end
    end

    // Result value by request kind
    always_comb begin
        if (cur_status != ST_OK) begin
            res_value = '0;
        end else begin
            unique case (r_req)
                REQ_SET, REQ_READ: res_value = r_old;
                REQ_CHECK:         res_value = r_sum;
                default:           res_value = '0;
            endcase
        end
    end

    // Output register: hold until the transaction is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value  <= res_value;
            r_out_total  <= {r_total[VAL_W-1], r_total[VAL_W-1:1]};
            r_out_status <= cur_status;
            r_out_mis    <= r_mis;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_value         = r_out_value;
    assign o_total_energy  = r_out_total;
    assign o_status        = r_out_status;
    assign o_sum_mismatch  = r_out_mis;

    // One memory access per cycle
    a_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.mem_rd && i_cmd.mem_wr))
        else $error("read and write issued together");

    // Accumulation only follows a row walk read
    a_acc_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc_vld |-> $past(i_cmd.acc_issue))
        else $error("accumulation without walk read");

    // Clearing the total leaves it zero
    a_total_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.total_clr |=> (r_total == '0))
        else $error("total not cleared");

endmodule

// ===== rtl/symmetric_pair_energy_table_core.sv =====
// Symmetric pair energy table: top level with stream ports.
//
// Input channel (i_s_axis_*): one transaction per request. tuser carries the
// request kind (set pair, read pair, recheck row, clear table); tdata carries
// both particle indices and the new Q16.16 pair energy.
// Output channel (o_m_axis_*): exactly one result transaction per request,
// with the value and the halved running total in tdata, status and the
// row-sum mismatch flag in tuser.
// Configuration: i_cfg_wr_en writes the particle count (default 64); the user must
// write it only while no request is in flight, which the block does not enforce.
// The single port of the pair store paces each request: a read does one fetch,
// a set three read-modify-writes, a recheck one row entry read per cycle over
// the effective particle count (at most 64), a clear one entry written per
// cycle; a rejected request goes straight to its result.
// A new request is accepted once the previous result is in the output register,
// even while that result still waits there.
// After reset the store is swept to zero, all 2080 entries; tready stays low
// during that sweep. When the receiver stalls, the result holds in the output
// register and the next finished request waits in the controller's done state.
module symmetric_pair_energy_table_core
    import spet_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [6:0]  i_cfg_wr_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // first_index[5:0], second_index[11:6],
                                          // pair_energy[43:12], zero[47:44]
    input  logic [1:0]  i_s_axis_tuser,   // req_type[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [95:0] o_m_axis_tdata,   // value[47:0], total_energy[95:48]
    output logic [2:0]  o_m_axis_tuser    // status[1:0], sum_mismatch[2]
);

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] total_energy;
    t_status          status;
    logic             sum_mismatch;

    // Sequence each request
    spet_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_stat          (stat),
        .o_s_axis_tready (o_s_axis_tready),
        .o_cmd           (cmd)
    );

    // Store, arithmetic and output register
    spet_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_req           (t_req'(i_s_axis_tuser)),
        .i_first_index   (i_s_axis_tdata[5:0]),
        .i_second_index  (i_s_axis_tdata[11:6]),
        .i_pair_energy   (i_s_axis_tdata[43:12]),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_value         (value),
        .o_total_energy  (total_energy),
        .o_status        (status),
        .o_sum_mismatch  (sum_mismatch)
    );

    // Pack the result transaction
    assign o_m_axis_tdata = {total_energy, value};
    assign o_m_axis_tuser = {sum_mismatch, status};

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the symmetric pair energy table core.
module tb;
    import spet_pkg::*;

    typedef struct {
        t_req        req;
        logic [5:0]  first;
        logic [5:0]  second;
        logic [31:0] energy;
    } t_pair_request;

    typedef struct {
        logic [47:0] value;
        logic [47:0] total;
        t_status     status;
        logic        mismatch;
    } t_energy_result;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [47:0] in_data = '0;
    logic [1:0]  in_user = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [95:0] out_data;
    logic [2:0]  out_user;

    // Predictor state: packed lower-triangular store, twice-total, particle count
    logic [47:0] energy_store [0:STORE_DEPTH-1];
    logic [47:0] twice_total;
    int          live_count;

    t_pair_request  request_queue [$];
    t_energy_result energy_expect [$];

    int in_taken = 0;
    int in_sent = 0;
    int req_added = 0;
    int results_seen = 0;
    int errors = 0;
    int send_gap = 0;
    int stall_left = 0;
    bit long_stall_done = 1'b0;
    bit quiet = 1'b0;

    symmetric_pair_energy_table_core i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_we),
        .i_cfg_wr_data   (cfg_data),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .i_s_axis_tuser  (in_user),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data),
        .o_m_axis_tuser  (out_user)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Store entry of the unordered pair (x, y)
    function automatic int entry_of(logic [5:0] x, logic [5:0] y);
        int hi;
        int lo;
        hi = (x > y) ? int'(x) : int'(y);
        lo = (x > y) ? int'(y) : int'(x);
        return hi * (hi + 1) / 2 + lo;
    endfunction

    // Apply one request to the predictor state and return its result
    function automatic t_energy_result pair_table_apply(t_req req, logic [5:0] a,
                                                        logic [5:0] b, logic [31:0] e);
        t_energy_result res;
        logic [47:0]    e48;
        logic [47:0]    old;
        logic [47:0]    delta;
        logic [47:0]    row_sum;
        int             n;
        int             da;
        int             db;
        res.value    = '0;
        res.status   = ST_OK;
        res.mismatch = 1'b0;
        n   = (live_count > MAX_PARTICLES) ? MAX_PARTICLES : live_count;
        e48 = {{16{e[31]}}, e};
        da  = entry_of(a, a);
        db  = entry_of(b, b);
        case (req)
            REQ_SET: begin
                if (int'(a) >= n || int'(b) >= n) begin
                    res.status = ST_RANGE;
                end else if (a == b) begin
                    res.status = ST_EQUAL;
                end else begin
                    old   = energy_store[entry_of(a, b)];
                    delta = e48 - old;
                    energy_store[entry_of(a, b)] = e48;
                    energy_store[da] = energy_store[da] + delta;
                    energy_store[db] = energy_store[db] + delta;
                    twice_total      = twice_total + {delta[46:0], 1'b0};
                    res.value        = old;
                end
            end
            REQ_READ: begin
                if (int'(a) >= n || int'(b) >= n) begin
                    res.status = ST_RANGE;
                end else begin
                    res.value = energy_store[entry_of(a, b)];
                end
            end
            REQ_CHECK: begin
                if (int'(a) >= n) begin
                    res.status = ST_RANGE;
                end else begin
                    row_sum = '0;
                    for (int w = 0; w < n; w++) begin
                        if (w != int'(a)) begin
                            row_sum = row_sum + energy_store[entry_of(a, w[5:0])];
                        end
                    end
                    // Correct a stale diagonal and move the total with it
                    if (row_sum != energy_store[da]) begin
                        twice_total      = twice_total + row_sum - energy_store[da];
                        energy_store[da] = row_sum;
                        res.mismatch     = 1'b1;
                    end
                    res.value = row_sum;
                end
            end
            REQ_CLEAR: begin
                foreach (energy_store[k]) energy_store[k] = '0;
                twice_total = '0;
            end
        endcase
        res.total = {twice_total[47], twice_total[47:1]};
        return res;
    endfunction

    // Mostly back to back, sometimes a short gap, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly an index in range, sometimes any index
    function automatic logic [5:0] pick_particle(int n);
        if (n == 0 || $urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, n - 1));
    endfunction

    task automatic add_request(t_req r, int a, int b, logic [31:0] e);
        t_pair_request item;
        item.req    = r;
        item.first  = 6'(a);
        item.second = 6'(b);
        item.energy = e;
        request_queue.push_back(item);
        req_added++;
    endtask

    task automatic write_particle_count(logic [6:0] v);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we     <= 1'b0;
        live_count = int'(v);
    endtask

    // Hold the sender until every queued request is taken and answered
    task automatic wait_for_results();
        while (results_seen < req_added) begin
            @(negedge clk);
        end
    endtask

    task automatic report_field(string name, logic [47:0] want, logic [47:0] got);
        if (want !== got) begin
            $error("%s expected %h got %h", name, want, got);
            errors++;
        end
    endtask

    // Input driver: advance to the next request once the current transaction is taken
    always @(negedge clk) begin : request_driver
        t_pair_request item;
        logic          next_valid;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            next_valid = in_valid;
            if (in_valid && in_taken != in_sent) begin
                in_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (request_queue.size() != 0) begin
                    item = request_queue.pop_front();
                    in_data    <= {4'b0, item.energy, item.second, item.first};
                    in_user    <= item.req;
                    next_valid = 1'b1;
                    send_gap   = pick_gap();
                end
            end
            in_valid <= next_valid;
        end
    end

    // Result receiver: random stalls plus one long hold-off to back the core up
    always @(negedge clk) begin : result_ready
        logic rdy;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (!long_stall_done && results_seen >= 200) begin
                stall_left      = 600;
                long_stall_done = 1'b1;
                rdy             = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
                rdy        = (stall_left == 0);
            end else begin
                rdy = 1'b1;
            end
            out_ready <= rdy;
        end
    end

    // Predict each accepted request
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            energy_expect.push_back(pair_table_apply(t_req'(in_user), in_data[5:0],
                                                     in_data[11:6], in_data[43:12]));
            in_taken <= in_taken + 1;
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge clk) begin : result_check
        t_energy_result want;
        if (rst_n && out_valid && out_ready) begin
            results_seen <= results_seen + 1;
            if (energy_expect.size() == 0) begin
                $error("result with no request outstanding: data %h user %h",
                       out_data, out_user);
                errors++;
            end else begin
                want = energy_expect.pop_front();
                report_field("value", want.value, out_data[47:0]);
                report_field("total_energy", want.total, out_data[95:48]);
                report_field("status", 48'(want.status), 48'(out_user[1:0]));
                report_field("sum_mismatch", 48'(want.mismatch), 48'(out_user[2]));
            end
        end
    end

    initial begin : stimulus
        t_req       r;
        int         pick;
        int         n;
        logic [5:0] a;
        logic [5:0] b;
        logic [31:0] e;
        logic [6:0] cnt;

        foreach (energy_store[k]) energy_store[k] = '0;
        twice_total = '0;
        live_count  = int'(COUNT_RESET);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset count: extremes of the energy, equal indices, row sums, clear
        add_request(REQ_SET, 0, 1, 32'h7FFF_FFFF);
        add_request(REQ_SET, 1, 0, 32'h8000_0000);
        add_request(REQ_SET, 63, 62, 32'hFFFF_FFFF);
        add_request(REQ_SET, 5, 5, 32'h0001_0000);
        add_request(REQ_READ, 0, 1, '0);
        add_request(REQ_READ, 63, 63, '0);
        add_request(REQ_CHECK, 63, 0, '0);
        add_request(REQ_CLEAR, 0, 0, '0);
        add_request(REQ_READ, 63, 62, '0);
        add_request(REQ_SET, 42, 21, 32'hAAAA_5555);
        add_request(REQ_SET, 0, 63, 32'h7FFF_FFFF);
        add_request(REQ_CHECK, 21, 0, '0);
        wait_for_results();

        // Small count: stale diagonal (odd total after the fix), range errors
        write_particle_count(7'd3);
        add_request(REQ_CHECK, 0, 0, '0);
        add_request(REQ_SET, 3, 0, 32'h1234_5678);
        add_request(REQ_READ, 2, 63, '0);
        add_request(REQ_SET, 1, 1, 32'h0000_0001);
        add_request(REQ_SET, 2, 0, 32'h0000_0001);
        wait_for_results();

        // Counts below two
        write_particle_count(7'd0);
        add_request(REQ_READ, 0, 0, '0);
        wait_for_results();
        write_particle_count(7'd1);
        add_request(REQ_SET, 0, 0, 32'h0000_0100);
        add_request(REQ_CHECK, 0, 0, '0);
        wait_for_results();

        // Counts above the table size are limited
        write_particle_count(7'd127);
        add_request(REQ_CHECK, 0, 0, '0);
        add_request(REQ_READ, 63, 0, '0);
        wait_for_results();
        write_particle_count(7'd65);
        add_request(REQ_CHECK, 63, 0, '0);
        wait_for_results();

        // Random phases; each ends with the sender held until all results are in
        for (int ph = 0; ph < 8; ph++) begin
            cnt = 7'($urandom_range(2, 64));
            case (ph)
                0, 2, 7: cnt = 7'd64;
                1:       cnt = 7'd2;
                4:       cnt = 7'd127;
                default: ;
            endcase
            write_particle_count(cnt);
            quiet = (ph == 3);
            n = (live_count > MAX_PARTICLES) ? MAX_PARTICLES : live_count;
            for (int i = 0; i < 116; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) r = REQ_SET;
                else if (pick < 70) r = REQ_READ;
                else if (pick < 97) r = REQ_CHECK;
                else r = REQ_CLEAR;
                a = pick_particle(n);
                b = ($urandom_range(0, 19) == 0) ? a : pick_particle(n);
                case ($urandom_range(0, 9))
                    0:       e = 32'h8000_0000;
                    1:       e = 32'h7FFF_FFFF;
                    default: e = $urandom;
                endcase
                add_request(r, a, b, e);
            end
            wait_for_results();
        end

        // Allow for any stray result after the last one
        repeat (2100) @(negedge clk);
        if (errors == 0 && energy_expect.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
